[hw/rtl/thick_line_to_quad_defines.svh]
// Assertion macros for the line-to-quad block.
`ifndef THICK_LINE_TO_QUAD_DEFINES_SVH
`define THICK_LINE_TO_QUAD_DEFINES_SVH

// Checked at every edge outside reset.
`define TLQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define TLQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tlq_pkg.sv]
package tlq_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = 31;   // floor sqrt of a sum below 2^61
  localparam int QUO_W     = 31;   // offset magnitude never exceeds |h|
  localparam int NUM_W     = 61;   // |h| * normalized component
  localparam int REG_IDX_W = 2;
  localparam int SUM_W     = 50;

  // valid-bit positions along the pipe
  localparam int ST_IN   = 0;
  localparam int ST_PROD = 1;
  localparam int ST_PT   = 2;
  localparam int ST_ORD  = 3;
  localparam int ST_LZ   = 4;
  localparam int ST_NRM  = 5;
  localparam int ST_SQ   = 6;
  localparam int ST_ROOT = ST_SQ + 1;          // root stage 0
  localparam int ST_DIV  = ST_ROOT + ROOT_W + 1;
  localparam int ST_FIN  = ST_DIV + QUO_W + 1;

  localparam logic [2:0] LAST_VERT = 3'd5;
  localparam logic signed [COORD_W-1:0] SCALE_ONE = 32'sd65536;
  localparam logic signed [SUM_W-1:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -50'sd2147483648;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCALE    = 2'd0,
    REG_OFFSET_X = 2'd1,
    REG_OFFSET_Y = 2'd2,
    REG_DEPTH_Z  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] h;
    logic                      vert;
    logic                      horiz;
    logic                      dy_pos;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [29:0] nmx;
    logic [29:0] nmy;
  } line_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[COORD_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sext(input logic signed [COORD_W-1:0] v);
    return {{(SUM_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [5:0] msb_pos(input logic [32:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

[hw/rtl/thick_line_to_quad.sv]
// Thick line to quad expander.
// Input channel: a line word (start_x/y, end_x/y, thickness, Q16.16) is taken at the
// rising edge where start is high and busy is low. Each line yields six vertex words
// (two triangles A1 B1 B2 / B2 A2 A1) on vert_x/y/z, each marked by vert_valid for one
// cycle; last_vertex flags the sixth. The receiver cannot stall.
// Config: cfg_we/cfg_index/cfg_data write scale, offset_x, offset_y, depth_z at the
// rising edge where cfg_we is high; write only while no line is in flight.
// Pipeline depth comes from a 31-stage square root and a 31-stage restoring divider,
// one bit per stage.
// Flow: the pipe takes a new line whenever busy is low, before earlier lines are out;
// it only holds (busy high) when a finished line waits for the vertex serializer,
// which sends six vertex words per line on the single output channel.
// Reset: clears every valid bit and the serializer, loads scale = 1.0 and zeros the
// offsets and depth; busy and vert_valid are low right after reset.
module thick_line_to_quad (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tlq_pkg::COORD_W-1:0]   start_x,
  input  logic signed [tlq_pkg::COORD_W-1:0]   start_y,
  input  logic signed [tlq_pkg::COORD_W-1:0]   end_x,
  input  logic signed [tlq_pkg::COORD_W-1:0]   end_y,
  input  logic        [tlq_pkg::COORD_W-2:0]   thickness,
  input  logic                                 cfg_we,
  input  logic        [tlq_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic        [tlq_pkg::COORD_W-1:0]   cfg_data,
  output logic                                 vert_valid,
  output logic signed [tlq_pkg::COORD_W-1:0]   vert_x,
  output logic signed [tlq_pkg::COORD_W-1:0]   vert_y,
  output logic signed [tlq_pkg::COORD_W-1:0]   vert_z,
  output logic                                 last_vertex
);
  import tlq_pkg::*;

  // config registers
  logic signed [COORD_W-1:0] scale, offset_x, offset_y, depth_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_ONE;
      offset_x <= '0;
      offset_y <= '0;
      depth_z  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCALE:    scale    <= cfg_data;
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_DEPTH_Z:  depth_z  <= cfg_data;
        default:      scale    <= scale;
      endcase
    end
  end

  // global hold: whole pipe moves together
  logic              adv;
  logic [ST_FIN:0]   vld;
  logic              ser_v;
  logic [2:0]        cnt;
  logic              ser_free;

  assign ser_free = !ser_v || (cnt == LAST_VERT);
  assign adv      = !vld[ST_FIN] || ser_free;
  assign busy     = !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[ST_FIN-1:0], start};
  end

  // input word
  logic signed [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic        [COORD_W-2:0] in_th;

  always_ff @(posedge clk) begin
    if (adv) begin
      in_sx <= start_x;
      in_sy <= start_y;
      in_ex <= end_x;
      in_ey <= end_y;
      in_th <= thickness;
    end
  end

  // products with scale
  logic signed [63:0] p_sx, p_sy, p_ex, p_ey, p_th;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sx <= in_sx * scale;
      p_sy <= in_sy * scale;
      p_ex <= in_ex * scale;
      p_ey <= in_ey * scale;
      p_th <= $signed({1'b0, in_th}) * scale;
    end
  end

  // divide by 2^FRAC_BITS toward zero, translate, saturate
  function automatic logic signed [SUM_W-1:0] scl_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (p[63] ? 64'sd65535 : 64'sd0)) >>> FRAC_BITS;
    return t[SUM_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] pt_ax, pt_ay, pt_bx, pt_by, pt_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_ax <= sat32(sext(offset_x) + scl_q(p_sx));
      pt_ay <= sat32(sext(offset_y) + scl_q(p_sy));
      pt_bx <= sat32(sext(offset_x) + scl_q(p_ex));
      pt_by <= sat32(sext(offset_y) + scl_q(p_ey));
      pt_w  <= sat32(scl_q(p_th));
    end
  end

  // order by x, deltas, half width
  side_t              ord_c;
  logic signed [32:0] dx_c, dy_c;
  logic        [32:0] my_c;
  side_t              ord_sd;
  logic        [32:0] ord_mx, ord_my;

  always_comb begin
    if (pt_ax < pt_bx) begin
      ord_c.x1 = pt_ax; ord_c.y1 = pt_ay; ord_c.x2 = pt_bx; ord_c.y2 = pt_by;
    end else begin
      ord_c.x1 = pt_bx; ord_c.y1 = pt_by; ord_c.x2 = pt_ax; ord_c.y2 = pt_ay;
    end
    dx_c = {ord_c.x2[COORD_W-1], ord_c.x2} - {ord_c.x1[COORD_W-1], ord_c.x1};
    dy_c = {ord_c.y2[COORD_W-1], ord_c.y2} - {ord_c.y1[COORD_W-1], ord_c.y1};
    my_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    ord_c.h = (pt_w + $signed({31'b0, pt_w[COORD_W-1]})) >>> 1;
    ord_c.vert   = (dx_c == '0);
    ord_c.horiz  = (dy_c == '0);
    ord_c.dy_pos = !dy_c[32] && (dy_c != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ord_sd <= ord_c;
      ord_mx <= dx_c;
      ord_my <= my_c;
    end
  end

  // normalize: find leading one, then shift
  side_t       lz_sd;
  logic [32:0] lz_mx, lz_my;
  logic        lz_right;
  logic [4:0]  lz_amt;
  logic [5:0]  pos_c;

  assign pos_c = msb_pos(ord_mx | ord_my);

  always_ff @(posedge clk) begin
    if (adv) begin
      lz_sd    <= ord_sd;
      lz_mx    <= ord_mx;
      lz_my    <= ord_my;
      lz_right <= (pos_c >= 6'd30);
      lz_amt   <= (pos_c >= 6'd30) ? 5'(pos_c - 6'd29) : 5'(6'd29 - pos_c);
    end
  end

  line_t       nrm_ln;
  logic [61:0] shx_c, shy_c;

  always_comb begin
    if (lz_right) begin
      shx_c = {29'b0, lz_mx} >> lz_amt;
      shy_c = {29'b0, lz_my} >> lz_amt;
    end else begin
      shx_c = {29'b0, lz_mx} << lz_amt;
      shy_c = {29'b0, lz_my} << lz_amt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_ln.sd  <= lz_sd;
      nrm_ln.nmx <= shx_c[29:0];
      nrm_ln.nmy <= shy_c[29:0];
    end
  end

  // squares
  line_t       sq_ln0;
  logic [59:0] sq_x, sq_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ln0 <= nrm_ln;
      sq_x   <= nrm_ln.nmx * nrm_ln.nmx;
      sq_y   <= nrm_ln.nmy * nrm_ln.nmy;
    end
  end

  // square root, one result bit per stage
  line_t              rt_ln   [0:ROOT_W];
  logic [NUM_W-1:0]   rt_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]  rt_root [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_ln[0]   <= sq_ln0;
      rt_rem[0]  <= {1'b0, sq_x} + {1'b0, sq_y};
      rt_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [63:0] trial;
    logic        fit;
    always_comb begin
      trial = ({33'b0, rt_root[k]} << (B + 1)) + (64'd1 << (2 * B));
      fit   = {3'b0, rt_rem[k]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_ln[k+1]   <= rt_ln[k];
        rt_rem[k+1]  <= fit ? rt_rem[k] - trial[NUM_W-1:0] : rt_rem[k];
        rt_root[k+1] <= fit ? (rt_root[k] | (ROOT_W'(1) << B)) : rt_root[k];
      end
    end
  end

  // numerators and restoring division by len
  side_t             dv_sd  [0:QUO_W];
  logic [ROOT_W-1:0] dv_len [0:QUO_W];
  logic [NUM_W-1:0]  dv_rx  [0:QUO_W];
  logic [NUM_W-1:0]  dv_ry  [0:QUO_W];
  logic [QUO_W-1:0]  dv_qx  [0:QUO_W];
  logic [QUO_W-1:0]  dv_qy  [0:QUO_W];
  logic signed [COORD_W-1:0] hneg_c;
  logic [30:0]       habs_c;

  assign hneg_c = -rt_ln[ROOT_W].sd.h;
  assign habs_c = rt_ln[ROOT_W].sd.h[COORD_W-1] ? hneg_c[30:0] : rt_ln[ROOT_W].sd.h[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sd[0]  <= rt_ln[ROOT_W].sd;
      dv_len[0] <= rt_root[ROOT_W];
      dv_rx[0]  <= habs_c * rt_ln[ROOT_W].nmy;
      dv_ry[0]  <= habs_c * rt_ln[ROOT_W].nmx;
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    logic [NUM_W:0] dsub;
    logic           fx, fy;
    always_comb begin
      dsub = {31'b0, dv_len[k]} << B;
      fx   = {1'b0, dv_rx[k]} >= dsub;
      fy   = {1'b0, dv_ry[k]} >= dsub;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sd[k+1]  <= dv_sd[k];
        dv_len[k+1] <= dv_len[k];
        dv_rx[k+1]  <= fx ? dv_rx[k] - dsub[NUM_W-1:0] : dv_rx[k];
        dv_ry[k+1]  <= fy ? dv_ry[k] - dsub[NUM_W-1:0] : dv_ry[k];
        dv_qx[k+1]  <= fx ? (dv_qx[k] | (QUO_W'(1) << B)) : dv_qx[k];
        dv_qy[k+1]  <= fy ? (dv_qy[k] | (QUO_W'(1) << B)) : dv_qy[k];
      end
    end
  end

  // offsets and corner vertices
  side_t                     fs;
  logic signed [COORD_W-1:0] xd_c, yd_c, ox_c, oy_c;
  logic signed [COORD_W-1:0] fin_a1x, fin_a1y, fin_b1x, fin_b1y;
  logic signed [COORD_W-1:0] fin_a2x, fin_a2y, fin_b2x, fin_b2y;

  always_comb begin
    fs   = dv_sd[QUO_W];
    xd_c = fs.h[COORD_W-1] ? -$signed({1'b0, dv_qx[QUO_W]}) : $signed({1'b0, dv_qx[QUO_W]});
    yd_c = (fs.h[COORD_W-1] ^ fs.dy_pos) ? -$signed({1'b0, dv_qy[QUO_W]})
                                         : $signed({1'b0, dv_qy[QUO_W]});
    if (fs.vert) begin
      ox_c = -fs.h;
      oy_c = '0;
    end else if (fs.horiz) begin
      ox_c = '0;
      oy_c = -fs.h;
    end else begin
      ox_c = xd_c;
      oy_c = yd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_a1x <= sat32(sext(fs.x1) + sext(ox_c));
      fin_a1y <= sat32(sext(fs.y1) + sext(oy_c));
      fin_b1x <= sat32(sext(fs.x1) - sext(ox_c));
      fin_b1y <= sat32(sext(fs.y1) - sext(oy_c));
      fin_a2x <= sat32(sext(fs.x2) + sext(ox_c));
      fin_a2y <= sat32(sext(fs.y2) + sext(oy_c));
      fin_b2x <= sat32(sext(fs.x2) - sext(ox_c));
      fin_b2y <= sat32(sext(fs.y2) - sext(oy_c));
    end
  end

  // vertex serializer: A1 B1 B2 B2 A2 A1
  logic signed [COORD_W-1:0] s_a1x, s_a1y, s_b1x, s_b1y, s_a2x, s_a2y, s_b2x, s_b2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      cnt   <= '0;
    end else if (vld[ST_FIN] && ser_free) begin
      ser_v <= 1'b1;
      cnt   <= '0;
    end else if (ser_v) begin
      if (cnt == LAST_VERT) ser_v <= 1'b0;
      else cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[ST_FIN] && ser_free) begin
      s_a1x <= fin_a1x; s_a1y <= fin_a1y;
      s_b1x <= fin_b1x; s_b1y <= fin_b1y;
      s_a2x <= fin_a2x; s_a2y <= fin_a2y;
      s_b2x <= fin_b2x; s_b2y <= fin_b2y;
    end
  end

  always_comb begin
    case (cnt)
      3'd0:          begin vert_x = s_a1x; vert_y = s_a1y; end
      3'd1:          begin vert_x = s_b1x; vert_y = s_b1y; end
      3'd2, 3'd3:    begin vert_x = s_b2x; vert_y = s_b2y; end
      3'd4:          begin vert_x = s_a2x; vert_y = s_a2y; end
      default:       begin vert_x = s_a1x; vert_y = s_a1y; end
    endcase
  end

  assign vert_valid  = ser_v;
  assign vert_z      = depth_z;
  assign last_vertex = ser_v && (cnt == LAST_VERT);

endmodule

[hw/rtl/tlq_checker.sv]
`include "thick_line_to_quad_defines.svh"

module tlq_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic vert_valid,
  input logic last_vertex
);
  // a vertex burst never breaks before its sixth word
  `TLQ_ASSERT(a_burst_contig, vert_valid && !last_vertex |=> vert_valid, "burst broke early")
  `TLQ_ASSERT(a_last_has_strobe, last_vertex |-> vert_valid, "last flag without strobe")
  `TLQ_ASSERT(a_six_words, last_vertex |-> $past(vert_valid, 5) && !$past(last_vertex, 1), "burst not six words")
  `TLQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !vert_valid && !busy, "not idle after reset")

endmodule

bind thick_line_to_quad tlq_checker u_tlq_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .vert_valid  (vert_valid),
  .last_vertex (last_vertex)
);

[verif/tb.sv]
module tb;
  import tlq_pkg::*;

  // one vertex word as it leaves the block
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } vertex_t;

  // one line word plus an optional typed first vertex
  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic        [30:0] th;
    bit                 typed;
    logic signed [31:0] a1x;
    logic signed [31:0] a1y;
  } line_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] start_x = '0;
  logic signed [31:0] start_y = '0;
  logic signed [31:0] end_x = '0;
  logic signed [31:0] end_y = '0;
  logic        [30:0] thickness = '0;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;
  logic               vert_valid;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic               last_vertex;

  // mirror of the block's registers
  logic signed [31:0] m_scale = SCALE_ONE;
  logic signed [31:0] m_off_x = '0;
  logic signed [31:0] m_off_y = '0;
  logic signed [31:0] m_depth = '0;

  vertex_t   pending_verts[$];
  line_row_t dir_rows[13];
  int        mismatches = 0;
  int        lines_sent = 0;
  int        verts_seen = 0;
  int        idle_cycles = 0;

  thick_line_to_quad DUT (
    .clk, .rst, .start, .busy, .start_x, .start_y, .end_x, .end_y, .thickness,
    .cfg_we, .cfg_index, .cfg_data, .vert_valid, .vert_x, .vert_y, .vert_z, .last_vertex
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 multiply by scale, truncated toward zero
  function automatic longint scaled(input longint v);
    longint p;
    p = v * longint'(m_scale);
    return p / 65536;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Builds the six vertices of the quad covering one thick line.
  task automatic expand_line(input line_row_t ln);
    longint ax, ay, bx, by, w, h, x1, y1, x2, y2, dx, dy, xd, yd;
    longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    longint unsigned mx, my, len, big;
    vertex_t v[6];
    ax = clamp32(longint'(m_off_x) + scaled(longint'(ln.sx)));
    ay = clamp32(longint'(m_off_y) + scaled(longint'(ln.sy)));
    bx = clamp32(longint'(m_off_x) + scaled(longint'(ln.ex)));
    by = clamp32(longint'(m_off_y) + scaled(longint'(ln.ey)));
    w = clamp32(scaled(longint'({33'd0, ln.th})));
    h = w / 2;
    if (ax < bx) begin
      x1 = ax; y1 = ay; x2 = bx; y2 = by;
    end else begin
      x1 = bx; y1 = by; x2 = ax; y2 = ay;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx == 0) begin
      // vertical, equal endpoints included
      p1x = x1 - h; p1y = y1; p2x = x2 - h; p2y = y2;
      q1x = x1 + h; q1y = y1; q2x = x2 + h; q2y = y2;
    end else if (dy == 0) begin
      p1x = x1; p1y = y1 - h; p2x = x2; p2y = y2 - h;
      q1x = x1; q1y = y1 + h; q2x = x2; q2y = y2 + h;
    end else begin
      mx = longint'(dx);
      my = (dy < 0) ? longint'(-dy) : longint'(dy);
      big = (mx > my) ? mx : my;
      while (big >= (64'd1 << 30)) begin
        mx = mx >> 1; my = my >> 1; big = (mx > my) ? mx : my;
      end
      while (big < (64'd1 << 29)) begin
        mx = mx << 1; my = my << 1; big = (mx > my) ? mx : my;
      end
      len = floor_root(mx * mx + my * my);
      if (len == 0) len = 1;
      xd = (h * longint'(my)) / longint'(len);
      yd = (h * longint'(mx)) / longint'(len);
      if (dy > 0) yd = -yd;
      p1x = x1 + xd; p1y = y1 + yd; p2x = x2 + xd; p2y = y2 + yd;
      q1x = x1 - xd; q1y = y1 - yd; q2x = x2 - xd; q2y = y2 - yd;
    end
    v[0] = '{32'(clamp32(p1x)), 32'(clamp32(p1y)), m_depth, 1'b0};
    v[1] = '{32'(clamp32(q1x)), 32'(clamp32(q1y)), m_depth, 1'b0};
    v[2] = '{32'(clamp32(q2x)), 32'(clamp32(q2y)), m_depth, 1'b0};
    v[3] = v[2];
    v[4] = '{32'(clamp32(p2x)), 32'(clamp32(p2y)), m_depth, 1'b0};
    v[5] = v[0];
    v[5].last = 1'b1;
    // hand-typed first vertex for the obvious rows
    if (ln.typed) begin
      v[0].x = ln.a1x;
      v[0].y = ln.a1y;
    end
    for (int i = 0; i < 6; i++) pending_verts.push_back(v[i]);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("MISMATCH vertex %0d %s: got %h want %h", verts_seen, what, got, want);
  endtask

  // Result checker: the block cannot be held off, so every strobe is a word.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vert_valid) begin
      if (pending_verts.size() == 0) begin
        report("unexpected", vert_x, 32'd0);
      end else begin
        e = pending_verts.pop_front();
        if (vert_x !== e.x) report("x", vert_x, e.x);
        if (vert_y !== e.y) report("y", vert_y, e.y);
        if (vert_z !== e.z) report("z", vert_z, e.z);
        if (last_vertex !== e.last) report("last", {31'd0, last_vertex}, {31'd0, e.last});
      end
      verts_seen++;
    end
  end

  // Watchdog: cycles without any handshake in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || vert_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d vertices outstanding", pending_verts.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // All tasks below are entered and left at a falling edge.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SCALE:    m_scale = val;
      REG_OFFSET_X: m_off_x = val;
      REG_OFFSET_Y: m_off_y = val;
      REG_DEPTH_Z:  m_depth = val;
      default: ;
    endcase
  endtask

  // Hold the sender until the quad pipe is empty.
  task automatic drain();
    while (pending_verts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_line(input line_row_t ln, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start = 1'b1;
    start_x = ln.sx;
    start_y = ln.sy;
    end_x = ln.ex;
    end_y = ln.ey;
    thickness = ln.th;
    do @(posedge clk); while (busy);
    expand_line(ln);
    lines_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  // Mostly sane lines, plus axis-aligned, degenerate and full-range noise.
  function automatic line_row_t rand_line();
    line_row_t ln;
    int kind, shape;
    kind = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    ln.sx = rand_coord(kind);
    ln.sy = rand_coord(kind);
    ln.ex = rand_coord(kind);
    ln.ey = rand_coord(kind);
    if (shape == 0) ln.ex = ln.sx;
    if (shape == 1) ln.ey = ln.sy;
    if (shape == 2) begin
      ln.ex = ln.sx;
      ln.ey = ln.sy;
    end
    ln.th = ($urandom_range(0, 2) == 0) ? 31'($urandom())
                                        : 31'($urandom_range(0, 32'h0010_0000));
    ln.typed = 1'b0;
    ln.a1x = '0;
    ln.a1y = '0;
    return ln;
  endfunction

  initial begin
    // register settings: scale, offset_x, offset_y, depth_z
    logic [31:0] cfg_sets[5][4];
    int idle_pct;
    int n;
    cfg_sets[0] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345};
    cfg_sets[1] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    cfg_sets[2] = '{32'h0000_0000, $urandom(), $urandom(), 32'h7FFF_FFFF};
    cfg_sets[3] = '{32'h0000_8000, $urandom(), $urandom(), $urandom()};
    cfg_sets[4] = '{32'hFFFD_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

    //           sx            sy            ex            ey            th           typed A1
    dir_rows[0]  = '{32'sd0, 32'sd0, 32'sd0, 32'sh000A_0000, 31'h0002_0000,
                     1'b1, -32'sd65536, 32'sh000A_0000};        // vertical
    dir_rows[1]  = '{32'sd0, 32'sd0, 32'sh0004_0000, 32'sd0, 31'h0002_0000,
                     1'b1, 32'sd0, -32'sd65536};                // horizontal
    dir_rows[2]  = '{32'sh0003_0000, 32'sh0005_0000, 32'sh0003_0000, 32'sh0005_0000,
                     31'd0, 1'b1, 32'sh0003_0000, 32'sh0005_0000}; // degenerate
    dir_rows[3]  = '{32'sd0, 32'sd0, 32'sh0003_0000, 32'sh0004_0000, 31'h000A_0000,
                     1'b0, 0, 0};                               // rising diagonal
    dir_rows[4]  = '{32'sd0, 32'sh0004_0000, 32'sh0003_0000, 32'sd0, 31'h000A_0000,
                     1'b0, 0, 0};                               // falling diagonal
    dir_rows[5]  = '{32'sh0005_0000, 32'sd0, 32'sh0001_0000, 32'sh0002_0000, 31'h0001_0000,
                     1'b0, 0, 0};                               // reversed order
    dir_rows[6]  = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     31'h7FFF_FFFF, 1'b0, 0, 0};
    dir_rows[7]  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     31'h7FFF_FFFF, 1'b0, 0, 0};
    dir_rows[8]  = '{32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF, 32'sd1, 31'h7FFF_FFFF,
                     1'b0, 0, 0};                               // vertical at the edge
    dir_rows[9]  = '{32'sd0, 32'sd0, 32'sd1, 32'sh7FFF_FFFF, 31'h0001_0000,
                     1'b0, 0, 0};                               // steep
    dir_rows[10] = '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sd1, 31'h0001_0000,
                     1'b0, 0, 0};                               // shallow
    dir_rows[11] = '{32'sd1, 32'sd2, 32'sd3, 32'sd5, 31'd1, 1'b0, 0, 0}; // h rounds to zero
    dir_rows[12] = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1, 32'sd0, 32'sd0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_line(dir_rows[i], 0);
    start = 1'b0;
    drain();   // sender pauses until every vertex is back

    n = 0;
    for (int s = 0; s < 5; s++) begin
      for (int r = 0; r < 4; r++) write_reg(reg_idx_t'(r), cfg_sets[s][r]);
      repeat (18) begin
        idle_pct = (n < 37) ? 20 : (n < 74) ? 68 : 0;
        send_line(rand_line(), idle_pct);
        n++;
      end
      start = 1'b0;
      drain();
    end
    // back to unit scale so the last phase ends on reset values
    write_reg(REG_SCALE, SCALE_ONE);
    write_reg(REG_OFFSET_X, 32'd0);
    write_reg(REG_OFFSET_Y, 32'd0);
    write_reg(REG_DEPTH_Z, 32'd0);
    repeat (10) send_line(rand_line(), 0);
    start = 1'b0;
    drain();

    $display("covered %0d lines / %0d vertices over 6 register settings", lines_sent, verts_seen);
    $display("axis-aligned, degenerate, saturating and signed-scale cases included");
    if (mismatches == 0 && pending_verts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
